>>> src/launch_control_evaluator_assert.svh
// assertion macros for the launch control evaluator
`ifndef LAUNCH_CONTROL_EVALUATOR_ASSERT_SVH
`define LAUNCH_CONTROL_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define LCE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("launch control evaluator: property failed");
// combination that must never be seen
`define LCE_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("launch control evaluator: forbidden combination");
`else
`define LCE_ASSERT(label, prop)
`define LCE_NEVER(label, expr)
`endif
`endif

>>> src/lce_pkg.sv
// types and constants of the launch control evaluator
package lce_pkg;

  // field widths
  localparam int RPM_W    = 14;
  localparam int SPEED_W  = 8;
  localparam int THR_W    = 10;
  localparam int CFG_W    = 14;
  localparam int PCT_W    = 7;
  localparam int SKIP_W   = 11;
  localparam int FUEL_W   = 8;
  localparam int SPAN_W   = 15;
  localparam int X_W      = 16;
  localparam int PROD_W   = PCT_W + SPAN_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int D2_W     = PROD_W + 1;

  // percentages
  localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
  localparam logic [FUEL_W-1:0] FUEL_BASE = 8'd100;

  // control word bit positions
  localparam int CW_EN_BIT     = 2;
  localparam int CW_SPARK_BIT  = 3;
  localparam int CW_FUEL_BIT   = 4;
  localparam int CW_TQ_EN_BIT  = 5;
  localparam int CW_TQ_BTN_BIT = 6;
  localparam int CW_ADDER_LSB  = 7;

  // cut percent fields
  localparam int CUT_FINAL_LSB = 7;

  typedef enum logic [2:0] {
    REG_LAUNCH_RPM     = 3'd0,
    REG_RPM_WINDOW     = 3'd1,
    REG_CORR_END_RPM   = 3'd2,
    REG_CUT_PERCENTS   = 3'd3,
    REG_SPEED_LIMIT    = 3'd4,
    REG_THROTTLE_THR   = 3'd5,
    REG_TORQUE_ARM_RPM = 3'd6,
    REG_CONTROL_WORD   = 3'd7
  } lce_reg_t;

  typedef enum logic [1:0] {
    SRC_SWITCH = 2'd0,
    SRC_CLUTCH = 2'd1,
    SRC_BRAKE  = 2'd2,
    SRC_ALWAYS = 2'd3
  } lce_src_t;

  typedef enum logic [1:0] {
    COND_NOT_MET = 2'd0,
    COND_PRE     = 2'd1,
    COND_LAUNCH  = 2'd2
  } lce_cond_t;

  // flags and results that ride alongside the ratio divider
  typedef struct packed {
    lce_cond_t          cond;
    logic               skip_full;
    logic               skip_div;
    logic               spark_cut;
    logic               fuel_cut;
    logic [FUEL_W-1:0]  fuel_percent;
    logic               source_ok;
    logic               speed_ok;
    logic               throttle_ok;
  } lce_side_t;

  // limit a percentage to 100
  function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] p);
    clamp_pct = (p > PCT_MAX) ? PCT_MAX : p;
  endfunction

endpackage

>>> src/launch_control_evaluator.sv
// launch control evaluator: condition, spark skip ratio, cut flags and fuel multiplier
//
// One engine sample is taken on every clock in which start is high; busy is always
// low. The result appears on the out_ ports for one cycle, marked by out_strobe, and
// samples leave in the order they arrive. Each sample passes through an input
// register, three set-up stages, the skip ratio divider, which settles one quotient
// bit per pipeline stage (RATIO_BITS + 1 stages), and an output register. Results
// cannot be held off, so the receiver must take each one in its strobe cycle.
// Configuration writes take effect at once and belong in idle periods, when no
// sample is in flight.
`include "launch_control_evaluator_assert.svh"

module launch_control_evaluator #(
  parameter int RATIO_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [lce_pkg::CFG_W-1:0]  cfg_wdata,
  // sample in
  input  logic                       start,
  output logic                       busy,
  input  logic [lce_pkg::RPM_W-1:0]  in_rpm,
  input  logic [lce_pkg::SPEED_W-1:0] in_speed_kmh,
  input  logic [lce_pkg::THR_W-1:0]  in_throttle,
  input  logic                       in_throttle_valid,
  input  logic                       in_switch_on,
  input  logic                       in_clutch_down,
  input  logic                       in_brake_down,
  // result out
  output logic                       out_strobe,
  output logic [1:0]                 out_condition,
  output logic [lce_pkg::SKIP_W-1:0] out_skip_ratio,
  output logic                       out_spark_cut,
  output logic                       out_fuel_cut,
  output logic [lce_pkg::FUEL_W-1:0] out_fuel_percent,
  output logic                       out_source_ok,
  output logic                       out_speed_ok,
  output logic                       out_throttle_ok
);
  import lce_pkg::*;

  localparam int QW   = RATIO_BITS + 1;
  localparam int NW   = SUM_W + RATIO_BITS + 2;
  localparam int SKW  = (QW > SKIP_W) ? QW : SKIP_W;
  localparam int LAT  = RATIO_BITS + 6;
  localparam logic [SKW-1:0] FULL_EXT = SKW'(1) << RATIO_BITS;
  localparam logic [QW-1:0]  FULL_Q   = QW'(1) << RATIO_BITS;

  // configuration registers
  logic [RPM_W-1:0]   launch_rpm_r;
  logic [RPM_W-1:0]   rpm_window_r;
  logic [RPM_W-1:0]   corr_end_rpm_r;
  logic [CFG_W-1:0]   cut_percents_r;
  logic [SPEED_W-1:0] speed_limit_r;
  logic [THR_W-1:0]   throttle_thr_r;
  logic [RPM_W-1:0]   torque_arm_rpm_r;
  logic [CFG_W-1:0]   control_word_r;

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_rpm_r     <= 14'd4000;
      rpm_window_r     <= 14'd500;
      corr_end_rpm_r   <= 14'd100;
      cut_percents_r   <= '0;
      speed_limit_r    <= '0;
      throttle_thr_r   <= '0;
      torque_arm_rpm_r <= '0;
      control_word_r   <= 14'd3;
    end else if (cfg_we) begin
      unique case (lce_reg_t'(cfg_index))
        REG_LAUNCH_RPM:     launch_rpm_r     <= cfg_wdata;
        REG_RPM_WINDOW:     rpm_window_r     <= cfg_wdata;
        REG_CORR_END_RPM:   corr_end_rpm_r   <= cfg_wdata;
        REG_CUT_PERCENTS:   cut_percents_r   <= cfg_wdata;
        REG_SPEED_LIMIT:    speed_limit_r    <= cfg_wdata[SPEED_W-1:0];
        REG_THROTTLE_THR:   throttle_thr_r   <= cfg_wdata[THR_W-1:0];
        REG_TORQUE_ARM_RPM: torque_arm_rpm_r <= cfg_wdata;
        REG_CONTROL_WORD:   control_word_r   <= cfg_wdata;
      endcase
    end
  end

  // every cycle takes a sample
  assign busy = 1'b0;

  // input register
  logic               in_vld_r;
  logic [RPM_W-1:0]   rpm_r;
  logic [SPEED_W-1:0] speed_r;
  logic [THR_W-1:0]   thr_r;
  logic               thr_valid_r;
  logic               sw_r;
  logic               clutch_r;
  logic               brake_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    rpm_r       <= in_rpm;
    speed_r     <= in_speed_kmh;
    thr_r       <= in_throttle;
    thr_valid_r <= in_throttle_valid;
    sw_r        <= in_switch_on;
    clutch_r    <= in_clutch_down;
    brake_r     <= in_brake_down;
  end

  // stage 1: gating, rpm condition and interpolation operands
  lce_src_t           src;
  logic               en, spark_en, fuel_en, tq_en, tq_btn;
  logic [PCT_W-1:0]   adder;
  logic signed [X_W-1:0] x_s, x1_s, x2_s, a_s, b_s, span_s;
  logic               tq_override, over;
  logic               src_ok, spd_ok, thr_ok;
  lce_cond_t          rpm_cond, cond;
  logic [SPAN_W-1:0]  a_nxt, b_nxt, span_nxt;
  lce_side_t          side_nxt;

  always_comb begin
    src      = lce_src_t'(control_word_r[1:0]);
    en       = control_word_r[CW_EN_BIT];
    spark_en = control_word_r[CW_SPARK_BIT];
    fuel_en  = control_word_r[CW_FUEL_BIT];
    tq_en    = control_word_r[CW_TQ_EN_BIT];
    tq_btn   = control_word_r[CW_TQ_BTN_BIT];
    adder    = control_word_r[CW_ADDER_LSB +: PCT_W];

    x_s  = $signed({2'b00, rpm_r});
    x1_s = $signed({2'b00, launch_rpm_r}) - $signed({2'b00, rpm_window_r});
    x2_s = $signed({2'b00, launch_rpm_r}) - $signed({2'b00, corr_end_rpm_r});

    // torque reduction button forces not met (switch source, enabled, rpm at or above arm rpm)
    tq_override = (src == SRC_SWITCH) && tq_btn && tq_en && (torque_arm_rpm_r <= rpm_r);

    priority if (tq_override) begin
      rpm_cond = COND_NOT_MET;
    end else if (x_s < x1_s) begin
      rpm_cond = COND_NOT_MET;
    end else if (launch_rpm_r <= rpm_r) begin
      rpm_cond = COND_LAUNCH;
    end else begin
      rpm_cond = COND_PRE;
    end

    unique case (src)
      SRC_SWITCH: src_ok = sw_r;
      SRC_CLUTCH: src_ok = clutch_r;
      SRC_BRAKE:  src_ok = brake_r;
      SRC_ALWAYS: src_ok = 1'b1;
    endcase
    spd_ok = (speed_limit_r == '0) || (speed_limit_r > speed_r);
    thr_ok = thr_valid_r && (throttle_thr_r < thr_r);

    if (!en) begin
      src_ok = 1'b0;
      spd_ok = 1'b0;
      thr_ok = 1'b0;
      cond   = COND_NOT_MET;
    end else begin
      cond = (src_ok && spd_ok && thr_ok) ? rpm_cond : COND_NOT_MET;
    end

    // end points go through the divider as a span of one
    a_s    = x2_s - x_s;
    b_s    = x_s - x1_s;
    span_s = x2_s - x1_s;
    priority if (x_s <= x1_s) begin
      a_nxt    = SPAN_W'(1);
      b_nxt    = '0;
      span_nxt = SPAN_W'(1);
    end else if (x_s >= x2_s) begin
      a_nxt    = '0;
      b_nxt    = SPAN_W'(1);
      span_nxt = SPAN_W'(1);
    end else begin
      a_nxt    = a_s[SPAN_W-1:0];
      b_nxt    = b_s[SPAN_W-1:0];
      span_nxt = span_s[SPAN_W-1:0];
    end

    over = (cond == COND_LAUNCH) && (launch_rpm_r < rpm_r);
    side_nxt.cond         = cond;
    side_nxt.skip_full    = spark_en && (cond == COND_LAUNCH);
    side_nxt.skip_div     = spark_en && (cond == COND_PRE);
    side_nxt.spark_cut    = over && spark_en;
    side_nxt.fuel_cut     = over && fuel_en;
    side_nxt.fuel_percent = FUEL_BASE + ((cond == COND_LAUNCH) ? {1'b0, adder} : '0);
    side_nxt.source_ok    = src_ok;
    side_nxt.speed_ok     = spd_ok;
    side_nxt.throttle_ok  = thr_ok;
  end

  logic              s1_vld_r;
  lce_side_t         s1_side_r;
  logic [SPAN_W-1:0] s1_a_r, s1_b_r, s1_span_r;
  logic [PCT_W-1:0]  s1_pi_r, s1_pf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r <= side_nxt;
    s1_a_r    <= a_nxt;
    s1_b_r    <= b_nxt;
    s1_span_r <= span_nxt;
    s1_pi_r   <= clamp_pct(cut_percents_r[PCT_W-1:0]);
    s1_pf_r   <= clamp_pct(cut_percents_r[CUT_FINAL_LSB +: PCT_W]);
  end

  // stage 2: weighted products and the scaled span
  logic              s2_vld_r;
  lce_side_t         s2_side_r;
  logic [PROD_W-1:0] s2_pa_r, s2_pb_r, s2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_side_r <= s1_side_r;
    s2_pa_r   <= PROD_W'(s1_pi_r) * PROD_W'(s1_a_r);
    s2_pb_r   <= PROD_W'(s1_pf_r) * PROD_W'(s1_b_r);
    s2_den_r  <= PROD_W'(PCT_MAX) * PROD_W'(s1_span_r);
  end

  // stage 3: rounded dividend and doubled divisor
  logic [SUM_W-1:0] num_sum;
  assign num_sum = SUM_W'(s2_pa_r) + SUM_W'(s2_pb_r);

  // divider pipeline, one quotient bit per stage, most significant first
  logic            dv_vld_r  [0:RATIO_BITS+1];
  lce_side_t       dv_side_r [0:RATIO_BITS+1];
  logic [QW-1:0]   dv_q_r    [0:RATIO_BITS+1];
  logic [NW-1:0]   dv_rem_r  [0:RATIO_BITS];
  logic [D2_W-1:0] dv_d2_r   [0:RATIO_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_side_r[0] <= s2_side_r;
    dv_q_r[0]    <= '0;
    dv_rem_r[0]  <= NW'({num_sum, {(RATIO_BITS + 1){1'b0}}}) + NW'(s2_den_r);
    dv_d2_r[0]   <= {s2_den_r, 1'b0};
  end

  for (genvar k = 0; k <= RATIO_BITS; k++) begin : g_div
    localparam int BIT = RATIO_BITS - k;
    logic [NW-1:0] dsh;
    logic          ge;
    logic [QW-1:0] q_nxt;

    // trial subtract of the divisor at this bit weight
    always_comb begin
      dsh        = NW'(dv_d2_r[k]) << BIT;
      ge         = dv_rem_r[k] >= dsh;
      q_nxt      = dv_q_r[k];
      q_nxt[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_side_r[k+1] <= dv_side_r[k];
      dv_q_r[k+1]    <= q_nxt;
    end

    if (k < RATIO_BITS) begin : g_rem
      always_ff @(posedge clk) begin
        dv_rem_r[k+1] <= ge ? (dv_rem_r[k] - dsh) : dv_rem_r[k];
        dv_d2_r[k+1]  <= dv_d2_r[k];
      end
    end
  end

  // output register, ratio selected by condition
  lce_side_t      fin_side;
  logic [QW-1:0]  skip_q;
  logic [SKW-1:0] skip_ext;

  always_comb begin
    fin_side = dv_side_r[RATIO_BITS+1];
    priority if (fin_side.skip_full) begin
      skip_q = FULL_Q;
    end else if (fin_side.skip_div) begin
      skip_q = dv_q_r[RATIO_BITS+1];
    end else begin
      skip_q = '0;
    end
    skip_ext = SKW'(skip_q);
  end

  logic              out_strobe_r;
  logic [1:0]        out_condition_r;
  logic [SKIP_W-1:0] out_skip_ratio_r;
  logic              out_spark_cut_r, out_fuel_cut_r;
  logic [FUEL_W-1:0] out_fuel_percent_r;
  logic              out_source_ok_r, out_speed_ok_r, out_throttle_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_vld_r[RATIO_BITS+1];
    end
  end

  always_ff @(posedge clk) begin
    out_condition_r    <= fin_side.cond;
    out_skip_ratio_r   <= skip_ext[SKIP_W-1:0];
    out_spark_cut_r    <= fin_side.spark_cut;
    out_fuel_cut_r     <= fin_side.fuel_cut;
    out_fuel_percent_r <= fin_side.fuel_percent;
    out_source_ok_r    <= fin_side.source_ok;
    out_speed_ok_r     <= fin_side.speed_ok;
    out_throttle_ok_r  <= fin_side.throttle_ok;
  end

  assign out_strobe       = out_strobe_r;
  assign out_condition    = out_condition_r;
  assign out_skip_ratio   = out_skip_ratio_r;
  assign out_spark_cut    = out_spark_cut_r;
  assign out_fuel_cut     = out_fuel_cut_r;
  assign out_fuel_percent = out_fuel_percent_r;
  assign out_source_ok    = out_source_ok_r;
  assign out_speed_ok     = out_speed_ok_r;
  assign out_throttle_ok  = out_throttle_ok_r;

  // checks
  `LCE_ASSERT(a_fixed_latency, (start && !busy) |-> ##LAT out_strobe)
  `LCE_ASSERT(a_cond_gated, (out_strobe && (out_condition != COND_NOT_MET)) |-> (out_source_ok && out_speed_ok && out_throttle_ok))
  `LCE_NEVER(a_spark_cut_full, out_strobe && out_spark_cut && (out_skip_ratio != FULL_EXT[SKIP_W-1:0]))

endmodule
